>>> src/target_tracking_pid_servo_unit_macros.svh
// Assertion macros for the target tracking PID servo unit.
// No dependencies; included by ttps_back, the RTL file that carries assertions.
`ifndef TARGET_TRACKING_PID_SERVO_UNIT_MACROS_SVH
`define TARGET_TRACKING_PID_SERVO_UNIT_MACROS_SVH

// same-cycle implication
`define TTPS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TTPS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ttps_pkg.sv
// Shared types and constants of the target tracking PID servo unit.
// No dependencies.
`default_nettype none
package ttps_pkg;

   localparam int FRAC = 12;
   localparam int CTR_X = 160;
   localparam int CTR_Y = 120;
   localparam int Q_DEPTH = 2;
   localparam int QPW = $clog2(Q_DEPTH);

   localparam logic [10:0] PULSE_MIN = 11'd1000;
   localparam logic [10:0] PULSE_MAX = 11'd2000;
   localparam logic [10:0] PULSE_MID = 11'd1500;
   localparam logic [12:0] ALPHA_ONE = 13'd4096;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_KP_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KP_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KI    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KD    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ILIM  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA = 3'd5;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
   localparam logic [STEP_W-1:0] ST_AVG   = 4'd1;
   localparam logic [STEP_W-1:0] ST_AMUL  = 4'd2;
   localparam logic [STEP_W-1:0] ST_LMUL  = 4'd3;
   localparam logic [STEP_W-1:0] ST_LSUM  = 4'd4;
   localparam logic [STEP_W-1:0] ST_ERR   = 4'd5;
   localparam logic [STEP_W-1:0] ST_PMUL  = 4'd6;
   localparam logic [STEP_W-1:0] ST_PSUM  = 4'd7;
   localparam logic [STEP_W-1:0] ST_SMUL  = 4'd8;
   localparam logic [STEP_W-1:0] ST_QOFF  = 4'd9;
   localparam logic [STEP_W-1:0] ST_DMUL  = 4'd10;
   localparam logic [STEP_W-1:0] ST_PULSE = 4'd11;
   localparam logic [STEP_W-1:0] ST_DONE  = 4'd12;

   typedef struct packed {
      logic [8:0] x;
      logic [7:0] y;
      logic       track;
   } frame_type;

   typedef struct packed {
      logic [15:0] kp_x;
      logic [15:0] kp_y;
      logic [15:0] ki;
      logic [15:0] kd;
      logic [11:0] ilim;
      logic [12:0] alpha;
   } cfg_type;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic              track;
   } axis_ctl_type;

endpackage
`default_nettype wire

>>> src/ttps_front.sv
// Front end: pairs receive words into frames and pushes them to the queue.
// Depends on ttps_pkg.
`default_nettype none
module ttps_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [15:0]         req_rx_word,
   input  wire logic                req_rx_error,
   input  wire logic                q_full,
   output logic                     q_push,
   output ttps_pkg::frame_type      q_data
);
   import ttps_pkg::*;

   logic        phase_ff, phase_in;
   logic [15:0] first_ff, first_in;
   logic        acc;

   assign req_stall = q_full;
   assign acc       = req_valid & ~q_full;
   assign q_push    = acc & ~req_rx_error & phase_ff;
   assign q_data    = '{x: first_ff[8:0], y: req_rx_word[7:0], track: req_rx_word[8]};

   always_comb begin
      phase_in = phase_ff;
      first_in = first_ff;
      if (acc) begin
         if (req_rx_error) begin
            phase_in = 1'b0;
         end else if (!phase_ff) begin
            phase_in = 1'b1;
            first_in = req_rx_word;
         end else begin
            phase_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         first_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         first_ff <= first_in;
      end
   end
endmodule
`default_nettype wire

>>> src/ttps_queue.sv
// Short frame queue between front and back.
// Depends on ttps_pkg.
`default_nettype none
module ttps_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire ttps_pkg::frame_type data_in,
   output logic                     full,
   input  wire logic                pop,
   output ttps_pkg::frame_type      data_out,
   output logic                     empty
);
   import ttps_pkg::*;

   frame_type      mem_ff [Q_DEPTH];
   logic [QPW-1:0] wr_ff, rd_ff;
   logic [QPW:0]   count_ff;
   logic           do_push, do_pop;

   assign full     = (count_ff == (QPW+1)'(Q_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign data_out = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == QPW'(Q_DEPTH-1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == QPW'(Q_DEPTH-1)) ? '0 : rd_ff + 1'b1;
         end
         count_ff <= count_ff + (QPW+1)'(do_push) - (QPW+1)'(do_pop);
      end
   end
endmodule
`default_nettype wire

>>> src/ttps_axis.sv
// One axis datapath: moving average, lowpass, PID and pulse scaling,
// stepped by the back-end sequencer. Depends on ttps_pkg.
`default_nettype none
module ttps_axis #(
   parameter int AVG_DEPTH = 5,
   parameter int SAMPLE_W  = 9,
   parameter int CENTER    = 160
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ttps_pkg::axis_ctl_type ctl,
   input  wire logic [SAMPLE_W-1:0]    sample,
   input  wire logic [15:0]            kp,
   input  wire logic [15:0]            ki,
   input  wire logic [15:0]            kd,
   input  wire logic [11:0]            ilim,
   input  wire logic [12:0]            alpha,
   output logic [10:0]                 pulse
);
   import ttps_pkg::*;

   localparam int SLW  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int TW   = SAMPLE_W + $clog2(AVG_DEPTH);
   localparam int SW   = SAMPLE_W + FRAC;
   localparam int KA   = TW + 5;
   localparam longint unsigned RA = ((64'd1 << (FRAC + KA)) + AVG_DEPTH - 1) / AVG_DEPTH;
   localparam int RAW  = FRAC + KA + 1;
   localparam int LW   = SW + 13;
   localparam int EW   = SW + 1;
   localparam int IW   = 25;
   localparam int ISW  = ((IW > EW) ? IW : EW) + 1;
   localparam int MW   = ((IW > EW + 1) ? IW : EW + 1) + 17;
   localparam int PSW  = MW + 2;
   localparam int SATW = 35;
   localparam longint SAT_LIM = 64'sd1 <<< (SATW - 1);
   localparam int PW   = SATW + 10;
   localparam int QEW  = PW - 2 * FRAC;
   localparam int QCAP = 601 * CENTER;
   localparam int QOFF = 1500 * CENTER;
   localparam int QW   = $clog2(2101 * CENTER + 1);
   localparam int KC   = QW + 8;
   localparam longint unsigned RC = ((64'd1 << KC) + CENTER - 1) / CENTER;
   localparam int RCW  = KC + 1;
   localparam logic [SW-1:0] CTR_Q = SW'(CENTER * 4096);

   logic [SAMPLE_W-1:0]    store_ff [AVG_DEPTH];
   logic [SLW-1:0]         slot_ff;
   logic [TW-1:0]          total_ff;
   logic [TW+RAW-1:0]      amul_ff;
   logic [LW-1:0]          lpa_ff, lpb_ff;
   logic [SW-1:0]          smooth_ff;
   logic signed [EW-1:0]   err_ff, last_ff;
   logic signed [EW:0]     diff_ff;
   logic signed [IW-1:0]   integ_ff;
   logic signed [MW-1:0]   pk_ff, pi_ff, pd_ff;
   logic signed [SATW-1:0] sum_ff;
   logic signed [PW-1:0]   pmul_ff;
   logic [QW-1:0]          qp_ff;
   logic [QW+RCW-1:0]      dmul_ff;
   logic [10:0]            held_ff;

   logic [SW-1:0]          avg, nv, smooth_in;
   logic [12:0]            a_eff, a_inv;
   logic [LW:0]            lp_sum;
   logic signed [EW-1:0]   err_calc;
   logic signed [ISW-1:0]  integ_sum, lim_e, integ_cl;
   logic signed [PSW-1:0]  psum;
   logic signed [SATW-1:0] sat;
   logic signed [QEW-1:0]  q, q_cl, q_sum;
   logic [11:0]            raw;
   logic [10:0]            pulse_in;

   assign avg       = amul_ff[KA +: SW];
   assign a_eff     = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
   assign a_inv     = ALPHA_ONE - a_eff;
   assign nv        = ctl.track ? avg : CTR_Q;
   assign lp_sum    = (LW+1)'(lpa_ff) + (LW+1)'(lpb_ff) + (LW+1)'(2048);
   assign smooth_in = lp_sum[FRAC +: SW];
   assign err_calc  = $signed({1'b0, CTR_Q}) - $signed({1'b0, smooth_ff});
   assign integ_sum = ISW'(integ_ff) + ISW'(err_calc);
   assign lim_e     = ISW'($signed({1'b0, ilim, 12'd0}));
   assign psum      = PSW'(pk_ff) + PSW'(pi_ff) + PSW'(pd_ff);
   assign q         = $signed(pmul_ff[PW-1:2*FRAC]);
   assign q_sum     = q_cl + QEW'(QOFF);
   assign raw       = dmul_ff[KC +: 12];
   assign pulse     = held_ff;

   always_comb begin
      if (integ_sum > lim_e) begin
         integ_cl = lim_e;
      end else if (integ_sum < -lim_e) begin
         integ_cl = -lim_e;
      end else begin
         integ_cl = integ_sum;
      end
      if (psum > PSW'(SAT_LIM - 1)) begin
         sat = SATW'(SAT_LIM - 1);
      end else if (psum < PSW'(-SAT_LIM)) begin
         sat = SATW'(-SAT_LIM);
      end else begin
         sat = SATW'(psum);
      end
      if (q > QEW'(QCAP)) begin
         q_cl = QEW'(QCAP);
      end else if (q < QEW'(-QCAP)) begin
         q_cl = QEW'(-QCAP);
      end else begin
         q_cl = q;
      end
      if (raw > 12'(PULSE_MAX)) begin
         pulse_in = PULSE_MAX;
      end else if (raw < 12'(PULSE_MIN)) begin
         pulse_in = PULSE_MIN;
      end else begin
         pulse_in = raw[10:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AVG_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
         slot_ff   <= '0;
         total_ff  <= '0;
         smooth_ff <= CTR_Q;
         integ_ff  <= '0;
         last_ff   <= '0;
         held_ff   <= PULSE_MID;
      end else begin
         case (ctl.step)
            ST_AVG: begin
               if (ctl.track) begin
                  total_ff          <= total_ff - TW'(store_ff[slot_ff]) + TW'(sample);
                  store_ff[slot_ff] <= sample;
                  slot_ff <= (slot_ff == SLW'(AVG_DEPTH-1)) ? '0 : slot_ff + 1'b1;
               end
            end
            ST_LSUM: begin
               smooth_ff <= smooth_in;
            end
            ST_ERR: begin
               if (ctl.track) begin
                  integ_ff <= IW'(integ_cl);
                  last_ff  <= err_calc;
               end else begin
                  integ_ff <= '0;
               end
            end
            ST_PULSE: begin
               if (ctl.track) begin
                  held_ff <= pulse_in;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (ctl.step)
         ST_AMUL: amul_ff <= (TW+RAW)'(total_ff) * (TW+RAW)'(RA);
         ST_LMUL: begin
            lpa_ff <= LW'(a_eff) * LW'(nv);
            lpb_ff <= LW'(a_inv) * LW'(smooth_ff);
         end
         ST_ERR: begin
            err_ff  <= err_calc;
            diff_ff <= (EW+1)'(err_calc) - (EW+1)'(last_ff);
         end
         ST_PMUL: begin
            pk_ff <= MW'($signed({1'b0, kp})) * MW'(err_ff);
            pi_ff <= MW'($signed({1'b0, ki})) * MW'(integ_ff);
            pd_ff <= MW'($signed({1'b0, kd})) * MW'(diff_ff);
         end
         ST_PSUM: sum_ff  <= sat;
         ST_SMUL: pmul_ff <= PW'(sum_ff) * PW'(10'sd333);
         ST_QOFF: qp_ff   <= q_sum[QW-1:0];
         ST_DMUL: dmul_ff <= (QW+RCW)'(qp_ff) * (QW+RCW)'(RC);
         default: begin
         end
      endcase
   end
endmodule
`default_nettype wire

>>> src/ttps_back.sv
// Back end: step sequencer, both axis datapaths and the result register.
// Depends on ttps_pkg, ttps_axis and the assertion macro header.
`default_nettype none
`include "target_tracking_pid_servo_unit_macros.svh"
module ttps_back #(
   parameter int AVG_DEPTH = 5
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ttps_pkg::frame_type q_data,
   input  wire logic                q_empty,
   output logic                     q_pop,
   input  wire ttps_pkg::cfg_type   cfg,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [10:0]              rsp_pulse_x,
   output logic [10:0]              rsp_pulse_y,
   output logic                     rsp_tracking
);
   import ttps_pkg::*;

   logic [STEP_W-1:0] state_ff, state_in;
   frame_type         cur_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [10:0]       px_ff, py_ff, px, py;
   logic              trk_ff;
   logic              out_free, load;
   axis_ctl_type      ctl;

   assign ctl       = '{step: state_ff, track: cur_ff.track};
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign load      = (state_ff == ST_DONE) & out_free;
   assign q_pop     = (state_ff == ST_IDLE) & ~q_empty;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pulse_x  = px_ff;
   assign rsp_pulse_y  = py_ff;
   assign rsp_tracking = trk_ff;

   ttps_axis #(.AVG_DEPTH(AVG_DEPTH), .SAMPLE_W(9), .CENTER(CTR_X)) u_axis_x (
      .clock(clock), .reset(reset), .ctl(ctl), .sample(cur_ff.x),
      .kp(cfg.kp_x), .ki(cfg.ki), .kd(cfg.kd), .ilim(cfg.ilim),
      .alpha(cfg.alpha), .pulse(px)
   );

   ttps_axis #(.AVG_DEPTH(AVG_DEPTH), .SAMPLE_W(8), .CENTER(CTR_Y)) u_axis_y (
      .clock(clock), .reset(reset), .ctl(ctl), .sample(cur_ff.y),
      .kp(cfg.kp_y), .ki(cfg.ki), .kd(cfg.kd), .ilim(cfg.ilim),
      .alpha(cfg.alpha), .pulse(py)
   );

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = q_empty ? ST_IDLE : ST_AVG;
         ST_DONE: state_in = out_free ? ST_IDLE : ST_DONE;
         default: begin
            if (state_ff inside {[ST_AVG:ST_PULSE]}) begin
               state_in = state_ff + 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_data;
      end
      if (load) begin
         px_ff  <= px;
         py_ff  <= py;
         trk_ff <= cur_ff.track;
      end
   end

   `TTPS_ASSERT_IMP(a_pulse_range, clock, reset, rsp_valid_ff, (px_ff >= PULSE_MIN && px_ff <= PULSE_MAX && py_ff >= PULSE_MIN && py_ff <= PULSE_MAX), "pulse out of range")
   `TTPS_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_DONE, "result without finished frame")
   `TTPS_ASSERT_NXT(a_start_frame, clock, reset, (state_ff == ST_IDLE && !q_empty), state_ff == ST_AVG, "queued frame not started")
endmodule
`default_nettype wire

>>> src/target_tracking_pid_servo_unit.sv
// Top level of the target tracking PID servo unit: CSR bank, front, queue, back.
// Depends on ttps_pkg, ttps_front, ttps_queue, ttps_back.
//
//   channel  direction  handshake         beat
//   req      in         req_valid/stall   rx_word, rx_error
//   rsp      out        rsp_valid/stall   pulse_x, pulse_y, tracking
//   csr      in         csr_valid/ready   index, wdata
//
// A receive word is taken whenever the frame queue is not full; a finished frame
// then runs through the back-end sequencer (one pop, eleven datapath steps, one load).
// The frame queue holds two frames, so the front keeps taking words while the
// back works or the result register is stalled, until the queue is full.
// Synchronous active-high reset; no clearing pass, the ready state is immediate.
`default_nettype none
module target_tracking_pid_servo_unit #(
   parameter int AVG_DEPTH = 5
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [15:0]                       req_rx_word,
   input  wire logic                              req_rx_error,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [10:0]                            rsp_pulse_x,
   output logic [10:0]                            rsp_pulse_y,
   output logic                                   rsp_tracking,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ttps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [15:0]                       csr_wdata
);
   import ttps_pkg::*;

   cfg_type   cfg_ff;
   frame_type f_data, q_data;
   logic      q_full, q_push, q_pop, q_empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp_x  <= 16'd4915;
         cfg_ff.kp_y  <= 16'd3482;
         cfg_ff.ki    <= 16'd41;
         cfg_ff.kd    <= 16'd1229;
         cfg_ff.ilim  <= 12'd100;
         cfg_ff.alpha <= 13'd1229;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_KP_X:  cfg_ff.kp_x  <= csr_wdata;
            CSR_KP_Y:  cfg_ff.kp_y  <= csr_wdata;
            CSR_KI:    cfg_ff.ki    <= csr_wdata;
            CSR_KD:    cfg_ff.kd    <= csr_wdata;
            CSR_ILIM:  cfg_ff.ilim  <= csr_wdata[11:0];
            CSR_ALPHA: cfg_ff.alpha <= csr_wdata[12:0];
            default: begin
            end
         endcase
      end
   end

   ttps_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_rx_word(req_rx_word), .req_rx_error(req_rx_error),
      .q_full(q_full), .q_push(q_push), .q_data(f_data)
   );

   ttps_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .data_in(f_data), .full(q_full),
      .pop(q_pop), .data_out(q_data), .empty(q_empty)
   );

   ttps_back #(.AVG_DEPTH(AVG_DEPTH)) u_back (
      .clock(clock), .reset(reset), .q_data(q_data), .q_empty(q_empty), .q_pop(q_pop),
      .cfg(cfg_ff), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pulse_x(rsp_pulse_x), .rsp_pulse_y(rsp_pulse_y), .rsp_tracking(rsp_tracking)
   );
endmodule
`default_nettype wire

>>> tb/target_tracking_pid_servo_unit_tb.sv
// Self-checking testbench for the target tracking PID servo unit.
// Drives paired and single receive words, receive errors and register settings, and predicts every pulse beat.
// Depends on ttps_pkg and target_tracking_pid_servo_unit.
`timescale 1ns / 1ps
module target_tracking_pid_servo_unit_tb;
   import ttps_pkg::*;

   localparam int DEPTH = 5;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic [15:0] word;
      logic        err;
   } rx_beat_t;

   typedef struct {
      logic [10:0] px;
      logic [10:0] py;
      logic        trk;
   } pulse_beat_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [15:0] req_rx_word = '0;
   logic req_rx_error = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [10:0] rsp_pulse_x;
   logic [10:0] rsp_pulse_y;
   logic rsp_tracking;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   rx_beat_t    rx_pending[$];
   pulse_beat_t pulses_due[$];
   int mismatches = 0;
   int quiet_cycles = 0;
   bit gaps_on = 1;

   // predictor state and register shadow
   longint kp_x, kp_y, ki, kd, ilim, alpha;
   bit          pair_half;
   logic [15:0] held_word;
   longint      win_x[DEPTH], win_y[DEPTH];
   int          win_slot;
   longint      sum_x, sum_y, filt_x, filt_y;
   longint      acc_x, acc_y, prev_x, prev_y;
   logic [10:0] hold_x, hold_y;

   target_tracking_pid_servo_unit i_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   function automatic longint smooth_toward(longint old, longint nv);
      longint a;
      a = (alpha > 4096) ? 4096 : alpha;
      return (a * nv + (4096 - a) * old + 2048) >>> 12;
   endfunction

   function automatic logic [10:0] pid_pulse(longint filt, longint ctr, longint kp,
                                               inout longint acc, inout longint prev);
      longint e, lim, s, num, den, cap, q;
      e = (ctr << 12) - filt;
      lim = ilim * 4096;
      acc = acc + e;
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      s = kp * e + ki * acc + kd * (e - prev);
      prev = e;
      num = s * 333;
      den = ctr << 24;
      cap = 600 * den;
      if (num > cap) num = cap;
      if (num < -cap) num = -cap;
      q = (num + 1500 * den) / den;
      if (q > 2000) q = 2000;
      if (q < 1000) q = 1000;
      return q[10:0];
   endfunction

   task automatic servo_step(rx_beat_t b);
      longint x, y;
      pulse_beat_t p;
      if (b.err) begin
         pair_half = 0;
         return;
      end
      if (!pair_half) begin
         held_word = b.word;
         pair_half = 1;
         return;
      end
      pair_half = 0;
      x = held_word[8:0];
      y = b.word[7:0];
      if (b.word[8]) begin
         sum_x = sum_x - win_x[win_slot] + x;
         sum_y = sum_y - win_y[win_slot] + y;
         win_x[win_slot] = x;
         win_y[win_slot] = y;
         win_slot = (win_slot + 1) % DEPTH;
         filt_x = smooth_toward(filt_x, (sum_x << 12) / DEPTH);
         filt_y = smooth_toward(filt_y, (sum_y << 12) / DEPTH);
         hold_x = pid_pulse(filt_x, CTR_X, kp_x, acc_x, prev_x);
         hold_y = pid_pulse(filt_y, CTR_Y, kp_y, acc_y, prev_y);
         p.trk = 1;
      end else begin
         acc_x = 0;
         acc_y = 0;
         filt_x = smooth_toward(filt_x, CTR_X << 12);
         filt_y = smooth_toward(filt_y, CTR_Y << 12);
         p.trk = 0;
      end
      p.px = hold_x;
      p.py = hold_y;
      pulses_due.push_back(p);
   endtask

   // driver
   always @(posedge clock) begin
      rx_beat_t b;
      bit free;
      if (reset) begin
         req_valid <= 0;
      end else begin
         free = !req_valid;
         if (req_valid && !req_stall) begin
            b.word = req_rx_word;
            b.err = req_rx_error;
            servo_step(b);
            free = 1;
         end
         if (free) begin
            if (rx_pending.size() > 0 && (!gaps_on || $urandom_range(99) >= 26)) begin
               b = rx_pending.pop_front();
               req_rx_word <= b.word;
               req_rx_error <= b.err;
               req_valid <= 1;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pulse_beat_t p;
      rsp_stall <= gaps_on && ($urandom_range(99) < 26);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pulses_due.size() == 0) begin
            report_mismatch("unexpected beat, pulse_x", rsp_pulse_x, 0);
         end else begin
            p = pulses_due.pop_front();
            if (rsp_pulse_x !== p.px) report_mismatch("pulse_x", rsp_pulse_x, p.px);
            if (rsp_pulse_y !== p.py) report_mismatch("pulse_y", rsp_pulse_y, p.py);
            if (rsp_tracking !== p.trk) report_mismatch("tracking", rsp_tracking, p.trk);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_KP_X:  kp_x = val;
         CSR_KP_Y:  kp_y = val;
         CSR_KI:    ki = val;
         CSR_KD:    kd = val;
         CSR_ILIM:  ilim = val[11:0];
         CSR_ALPHA: alpha = val[12:0];
         default: ;
      endcase
   endtask

   task automatic write_all(logic [15:0] kpx, logic [15:0] kpy, logic [15:0] i_g,
                            logic [15:0] d_g, logic [15:0] lim, logic [15:0] a);
      write_reg(CSR_KP_X, kpx);
      write_reg(CSR_KP_Y, kpy);
      write_reg(CSR_KI, i_g);
      write_reg(CSR_KD, d_g);
      write_reg(CSR_ILIM, lim);
      write_reg(CSR_ALPHA, a);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic push_word(logic [15:0] w, logic e);
      rx_beat_t b;
      b.word = w;
      b.err = e;
      rx_pending.push_back(b);
   endtask

   task automatic push_frame(logic [8:0] x, logic trk, logic [7:0] y);
      push_word({7'($urandom_range(127)), x}, 1'b0);
      push_word({7'($urandom_range(127)), trk, y}, 1'b0);
   endtask

   task automatic drain;
      while (rx_pending.size() > 0 || req_valid || pulses_due.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic random_traffic(int n);
      int r;
      for (int i = 0; i < n; i += 2) begin
         r = $urandom_range(99);
         if (r < 78)
            push_frame(9'($urandom_range(511)), 1'b1, 8'($urandom_range(255)));
         else if (r < 88)
            push_frame(9'($urandom_range(511)), 1'b0, 8'($urandom_range(255)));
         else if (r < 94) push_word(16'($urandom), 1'b1);
         else             push_word(16'($urandom), 1'b0);
      end
   endtask

   initial begin
      kp_x = 4915; kp_y = 3482; ki = 41; kd = 1229; ilim = 100; alpha = 1229;
      pair_half = 0; held_word = '0; win_slot = 0;
      for (int i = 0; i < DEPTH; i++) begin
         win_x[i] = 0;
         win_y[i] = 0;
      end
      sum_x = 0; sum_y = 0;
      filt_x = CTR_X << 12; filt_y = CTR_Y << 12;
      acc_x = 0; acc_y = 0; prev_x = 0; prev_y = 0;
      hold_x = PULSE_MID; hold_y = PULSE_MID;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: reset settings, field extremes, invalid frames, receive errors
      push_frame(9'd0, 1'b1, 8'd0);
      push_frame(9'd511, 1'b1, 8'd255);
      push_word(16'hFFFF, 1'b0);
      push_word(16'hFFFF, 1'b0);
      push_frame(9'd160, 1'b1, 8'd120);
      push_frame(9'd300, 1'b0, 8'd200);
      push_word(16'h0000, 1'b1);
      push_word(16'h0123, 1'b0);
      push_word(16'hFFFF, 1'b1);
      push_frame(9'd17, 1'b1, 8'd33);
      push_word(16'h0000, 1'b0);
      push_word(16'h0000, 1'b0);
      push_frame(9'd511, 1'b0, 8'd0);
      push_frame(9'd0, 1'b1, 8'd255);
      drain();

      write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd4095, 16'd4096);
      random_traffic(200);
      drain();
      write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      random_traffic(120);
      drain();
      write_all(16'd4915, 16'd3482, 16'd41, 16'd1229, 16'd100, 16'h1FFF);
      random_traffic(160);
      drain();
      gaps_on = 0;
      write_all(16'($urandom), 16'($urandom), 16'($urandom_range(2000)), 16'($urandom),
                16'd4095, 16'd1);
      random_traffic(300);
      drain();
      gaps_on = 1;
      for (int ph = 0; ph < 5; ph++) begin
         write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom_range(4095)), 16'($urandom_range(8191)));
         random_traffic(250);
         drain();
      end

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
